### hdl/brst_pkg.sv
// ----------------------------------------------------------------------------
// brst_pkg
// shared constants for the bit map range set / all-set test unit
// ----------------------------------------------------------------------------
package brst_pkg;

  // default map geometry
  localparam int MAP_BITS_DEF  = 65536;
  localparam int WORD_BITS_DEF = 64;

  // fixed field widths of a request
  localparam int IDX_W = 16;  // range_start and last bit index
  localparam int END_W = 17;  // range_end

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // request function codes
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_PAST_END = 2'd2;

endpackage

### hdl/bitmap_range_set_and_test_unit.sv
// ----------------------------------------------------------------------------
// bitmap_range_set_and_test_unit
// bit map with range set and range all-set test
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result comes
// back as a one-cycle done strobe with all_set and status; the receiver
// cannot stall it, so sample on done. Status: ok, empty or reversed range
// (range_end <= range_start, checked first), or range past the map end.
// Bit n sits in word n/WORD_BITS, MSB-first inside the word. After reset
// the store's ceil(min(MAP_BITS, 65536) / WORD_BITS) words (1024 at the
// defaults) are swept to zero, one word a cycle, with busy held high. In
// the front a request gets its range check and reciprocal multiply as it
// is taken, its word / offset split next, and then waits to be pushed
// while the queue is full. The back then reads one store word a cycle
// through its read port and writes it back through a separate write port
// on set; a bad request is answered without a walk. The queue lets the
// front take the next request while the back still walks the previous one.
// ----------------------------------------------------------------------------
module bitmap_range_set_and_test_unit import brst_pkg::*; #(
  parameter int MAP_BITS  = MAP_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             func,
  input  logic [IDX_W-1:0] range_start,
  input  logic [END_W-1:0] range_end,
  output logic             done,
  output logic             all_set,
  output logic [1:0]       status
);

  // store geometry; indexes never reach beyond 2**IDX_W bits
  localparam int EFF_BITS = (MAP_BITS < (1 << IDX_W)) ? MAP_BITS : (1 << IDX_W);
  localparam int DEPTH    = (EFF_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W    = $clog2(WORD_BITS);
  // func, status, first / last word, first / last offset
  localparam int ENTRY_W  = 3 + 2 * ADDR_W + 2 * OFF_W;

  logic               front_busy;
  logic               clearing;
  logic               accept;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_in;
  logic [ENTRY_W-1:0] q_out;

  // no new request during the clearing sweep or while the front holds one
  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  // front: range checks and word / offset split of both range ends
  brst_front #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func),
    .range_start (range_start),
    .range_end   (range_end),
    .busy        (front_busy),
    .push        (q_push),
    .full        (q_full),
    .entry       (q_in)
  );

  // classified requests wait here, in order, for the back
  brst_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // back: owns the store, clears it after reset, walks each range
  brst_back #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .empty    (q_empty),
    .pop      (q_pop),
    .entry    (q_out),
    .done     (done),
    .all_set  (all_set),
    .status   (status)
  );

endmodule

### hdl/brst_queue.sv
// ----------------------------------------------------------------------------
// brst_queue
// small first-in first-out queue of classified requests
// ----------------------------------------------------------------------------
module brst_queue import brst_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/brst_front.sv
// ----------------------------------------------------------------------------
// brst_front
// takes a request, checks its range and splits both ends into word / offset
// ----------------------------------------------------------------------------
module brst_front import brst_pkg::*; #(
  parameter int MAP_BITS  = MAP_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             func,
  input  logic [IDX_W-1:0] range_start,
  input  logic [END_W-1:0] range_end,
  output logic             busy,
  output logic             push,
  input  logic             full,
  output logic [3 + 2 * ((((((MAP_BITS < (1 << IDX_W)) ? MAP_BITS : (1 << IDX_W))
                 + WORD_BITS - 1) / WORD_BITS) > 1) ? $clog2((((MAP_BITS < (1 << IDX_W))
                 ? MAP_BITS : (1 << IDX_W)) + WORD_BITS - 1) / WORD_BITS) : 1)
                 + 2 * $clog2(WORD_BITS) - 1:0] entry
);

  localparam int EFF_BITS = (MAP_BITS < (1 << IDX_W)) ? MAP_BITS : (1 << IDX_W);
  localparam int DEPTH    = (EFF_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W    = $clog2(WORD_BITS);
  // reciprocal of the word size, exact for every index below 2**IDX_W
  localparam int SHIFT    = IDX_W + OFF_W;
  localparam int RECIP    = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W  = SHIFT - OFF_W + 1;
  localparam int PROD_W   = IDX_W + RECIP_W + 1;

  typedef struct packed {
    logic              func;
    logic [1:0]        status;
    logic [ADDR_W-1:0] w_first;
    logic [ADDR_W-1:0] w_last;
    logic [OFF_W-1:0]  off_first;
    logic [OFF_W-1:0]  off_last;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t      state;
  front_state_t      state_next;
  logic              func_q;
  logic [1:0]        status_q;
  logic [IDX_W-1:0]  left_q;
  logic [IDX_W-1:0]  last_q;
  logic [IDX_W-1:0]  last_in;
  logic [PROD_W-1:0] prod_l;
  logic [PROD_W-1:0] prod_r;
  logic [ADDR_W-1:0] q_l;
  logic [ADDR_W-1:0] q_r;
  logic [IDX_W-1:0]  qw_l;
  logic [IDX_W-1:0]  qw_r;
  logic [IDX_W-1:0]  rem_l;
  logic [IDX_W-1:0]  rem_r;
  logic [1:0]        status_in;
  entry_t            ent;

  assign last_in = IDX_W'(range_end - 1'b1);

  always_comb begin
    priority if (range_end <= {1'b0, range_start}) begin
      status_in = ST_EMPTY;
    end else if (range_end > END_W'(EFF_BITS)) begin
      status_in = ST_PAST_END;
    end else begin
      status_in = ST_OK;
    end
  end

  assign rem_l = left_q - qw_l;
  assign rem_r = last_q - qw_r;

  always_comb begin
    ent.func      = func_q;
    ent.status    = status_q;
    ent.w_first   = q_l;
    ent.w_last    = q_r;
    ent.off_first = rem_l[OFF_W-1:0];
    ent.off_last  = rem_r[OFF_W-1:0];
  end

  assign entry = ent;
  assign busy  = (state != F_IDLE);
  assign push  = (state == F_PUSH) && !full;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = F_MUL;
      end
      F_MUL:  state_next = F_PUSH;
      F_PUSH: begin
        if (!full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
      if (accept && state == F_IDLE) begin
        func_q   <= func;
        status_q <= status_in;
        left_q   <= range_start;
        last_q   <= last_in;
        prod_l   <= PROD_W'(range_start) * PROD_W'(RECIP);
        prod_r   <= PROD_W'(last_in) * PROD_W'(RECIP);
      end
      if (state == F_MUL) begin
        q_l  <= prod_l[SHIFT +: ADDR_W];
        q_r  <= prod_r[SHIFT +: ADDR_W];
        qw_l <= IDX_W'(prod_l[SHIFT +: ADDR_W]) * IDX_W'(WORD_BITS);
        qw_r <= IDX_W'(prod_r[SHIFT +: ADDR_W]) * IDX_W'(WORD_BITS);
      end
    end
  end

endmodule

### hdl/brst_back.sv
// ----------------------------------------------------------------------------
// brst_back
// walks the store words of a request: read, then or-in or check the mask
// ----------------------------------------------------------------------------
module brst_back import brst_pkg::*; #(
  parameter int MAP_BITS  = MAP_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  output logic       clearing,
  input  logic       empty,
  output logic       pop,
  input  logic [3 + 2 * ((((((MAP_BITS < (1 << IDX_W)) ? MAP_BITS : (1 << IDX_W))
                 + WORD_BITS - 1) / WORD_BITS) > 1) ? $clog2((((MAP_BITS < (1 << IDX_W))
                 ? MAP_BITS : (1 << IDX_W)) + WORD_BITS - 1) / WORD_BITS) : 1)
                 + 2 * $clog2(WORD_BITS) - 1:0] entry,
  output logic       done,
  output logic       all_set,
  output logic [1:0] status
);

  localparam int EFF_BITS = (MAP_BITS < (1 << IDX_W)) ? MAP_BITS : (1 << IDX_W);
  localparam int DEPTH    = (EFF_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W    = $clog2(WORD_BITS);

  typedef struct packed {
    logic              func;
    logic [1:0]        status;
    logic [ADDR_W-1:0] w_first;
    logic [ADDR_W-1:0] w_last;
    logic [OFF_W-1:0]  off_first;
    logic [OFF_W-1:0]  off_last;
  } entry_t;

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_WALK  = 4'b0100,
    B_DRAIN = 4'b1000
  } back_state_t;

  logic [WORD_BITS-1:0] mem [DEPTH];

  back_state_t          state;
  back_state_t          state_next;
  entry_t               head;
  logic [ADDR_W-1:0]    clr_addr;
  logic                 func_q;
  logic [ADDR_W-1:0]    addr;
  logic [ADDR_W-1:0]    w_first;
  logic [ADDR_W-1:0]    w_last;
  logic [WORD_BITS-1:0] mask_first;
  logic [WORD_BITS-1:0] mask_last;
  logic                 acc;
  logic                 rd_en;
  logic                 rd_v;
  logic                 rd_first;
  logic                 rd_last;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] word_mask;
  logic                 acc_upd;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  assign head     = entry;
  assign clearing = (state == B_CLEAR);

  // edge words take partial masks, inner words are whole
  assign word_mask = (rd_first ? mask_first : '1) & (rd_last ? mask_last : '1);
  assign acc_upd   = acc && ((rd_data & word_mask) == word_mask);

  assign mem_we = clearing || (rd_v && func_q == FUNC_SET);
  assign mem_wa = clearing ? clr_addr : rd_addr;
  assign mem_wd = clearing ? '0 : (rd_data | word_mask);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    unique case (state)
      B_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.status == ST_OK) state_next = B_WALK;
        end
      end
      B_WALK: begin
        rd_en = 1'b1;
        if (addr == w_last) state_next = B_DRAIN;
      end
      B_DRAIN: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      rd_v     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= rd_en;
      done  <= 1'b0;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (pop) begin
        if (head.status != ST_OK) begin
          done    <= 1'b1;
          all_set <= 1'b0;
          status  <= head.status;
        end else begin
          func_q     <= head.func;
          addr       <= head.w_first;
          w_first    <= head.w_first;
          w_last     <= head.w_last;
          mask_first <= {WORD_BITS{1'b1}} >> head.off_first;
          mask_last  <= {WORD_BITS{1'b1}} << (OFF_W'(WORD_BITS - 1) - head.off_last);
          acc        <= 1'b1;
        end
      end
      if (rd_en) begin
        addr     <= addr + 1'b1;
        rd_addr  <= addr;
        rd_first <= (addr == w_first);
        rd_last  <= (addr == w_last);
      end
      if (rd_v) begin
        acc <= acc_upd;
        if (rd_last) begin
          done    <= 1'b1;
          all_set <= (func_q == FUNC_TEST) ? acc_upd : 1'b1;
          status  <= ST_OK;
        end
      end
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// bench for the bit map range set / all-set test unit: directed range cases,
// then windowed random traffic, each reply checked against a local bit map
// ----------------------------------------------------------------------------
module tb;
  import brst_pkg::*;

  // map geometry as built by the unit with its default parameters
  localparam int unsigned MAP_SIZE  = MAP_BITS_DEF;
  localparam int unsigned WORD      = WORD_BITS_DEF;
  localparam int unsigned MAP_WORDS = (MAP_SIZE + WORD - 1) / WORD;

  // random traffic works inside 1024-bit windows below the directed area
  localparam int unsigned WINDOW_BITS  = 1024;
  localparam int unsigned WINDOW_COUNT = 56;
  localparam int unsigned TOP_BASE     = WINDOW_BITS * WINDOW_COUNT;
  localparam int unsigned RANDOM_ITEMS = 1800;

  // longest stretch with no beat: clearing sweep or a full-map walk, queued
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = MAP_WORDS + 16;

  typedef struct packed {
    logic       all_set;
    logic [1:0] status;
  } reply_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             func = FUNC_SET;
  logic [IDX_W-1:0] range_start = '0;
  logic [END_W-1:0] range_end = '0;
  logic             done;
  logic             all_set;
  logic [1:0]       status;

  bitmap_range_set_and_test_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .range_start (range_start),
    .range_end   (range_end),
    .done        (done),
    .all_set     (all_set),
    .status      (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copy of the bit map, MSB-first inside each word
  logic [WORD-1:0] map_words [0:MAP_WORDS-1];

  // replies still owed by the unit, oldest first
  reply_t expected_replies [$];

  int unsigned err_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned random_sent = 0;
  int unsigned n_set = 0;
  int unsigned n_test = 0;
  int unsigned n_rejected = 0;
  int unsigned n_hits = 0;

  // apply one request to the local map and return the reply it must produce
  function automatic reply_t predict_request(logic f, logic [IDX_W-1:0] lo_f,
                                             logic [END_W-1:0] hi_f);
    reply_t          r;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     last_bit;
    int unsigned     a;
    int unsigned     b;
    logic [WORD-1:0] m;
    lo = 32'(lo_f);
    hi = 32'(hi_f);
    r.all_set = 1'b1;
    r.status  = ST_OK;
    // empty or reversed range wins over the past-end check
    if (hi <= lo) begin
      r.all_set = 1'b0;
      r.status  = ST_EMPTY;
      return r;
    end
    if (hi > MAP_SIZE) begin
      r.all_set = 1'b0;
      r.status  = ST_PAST_END;
      return r;
    end
    last_bit = hi - 1;
    for (int unsigned w = lo / WORD; w <= last_bit / WORD; w++) begin
      // edge words get partial masks, inner words are whole
      a = (w == lo / WORD) ? lo % WORD : 0;
      b = (w == last_bit / WORD) ? last_bit % WORD : WORD - 1;
      m = ({WORD{1'b1}} >> a) & ({WORD{1'b1}} << (WORD - 1 - b));
      if (f == FUNC_SET)
        map_words[w] |= m;
      else if ((map_words[w] & m) != m)
        r.all_set = 1'b0;
    end
    return r;
  endfunction

  // span length for window traffic: mostly short, sometimes up to a whole window
  function automatic int unsigned pick_span();
    if ($urandom_range(0, 9) < 7)
      return $urandom_range(1, 128);
    return $urandom_range(1, WINDOW_BITS);
  endfunction

  // drive one request beat; the sender mostly idles between bursts of random length
  task automatic send_request(input logic f, input int unsigned lo,
                              input int unsigned hi);
    int unsigned gap;
    reply_t      r;
    if (burst_left == 0) begin
      // a quarter of the bursts follow on with no idle cycle at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start       <= 1'b1;
    func        <= f;
    range_start <= lo[IDX_W-1:0];
    range_end   <= hi[END_W-1:0];
    // busy is read before this edge's updates land, so this is the beat
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_request(f, lo[IDX_W-1:0], hi[END_W-1:0]);
    expected_replies.push_back(r);
    if (r.status != ST_OK)
      n_rejected++;
    else if (f == FUNC_SET)
      n_set++;
    else begin
      n_test++;
      if (r.all_set)
        n_hits++;
    end
  endtask

  // sender holds off until every owed reply has come back
  task automatic wait_replies_drained();
    start <= 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // empty, reversed and past-end ranges, including the widest range_end
  task automatic test_rejected_ranges();
    send_request(FUNC_SET, 0, 0);
    send_request(FUNC_TEST, 100, 50);
    send_request(FUNC_SET, 65535, 65535);
    send_request(FUNC_TEST, 65535, 0);
    send_request(FUNC_TEST, 0, MAP_SIZE + 1);
    send_request(FUNC_SET, 65535, 131071);
    send_request(FUNC_SET, 0, 131071);
  endtask

  // single bits, word-crossing spans and a multi-word span in the top area
  task automatic test_word_edges();
    send_request(FUNC_TEST, TOP_BASE, TOP_BASE + 1);
    send_request(FUNC_SET, TOP_BASE, TOP_BASE + 1);
    send_request(FUNC_TEST, TOP_BASE, TOP_BASE + 1);
    // last bit of one word and first bit of the next
    send_request(FUNC_SET, TOP_BASE + WORD - 1, TOP_BASE + WORD + 1);
    send_request(FUNC_TEST, TOP_BASE + WORD - 1, TOP_BASE + WORD + 1);
    // hole between the two marks
    send_request(FUNC_TEST, TOP_BASE, TOP_BASE + WORD + 1);
    // multi-word span with a ragged start and an aligned end, then probes just inside and outside
    send_request(FUNC_SET, 58000, 61440);
    send_request(FUNC_TEST, 58000, 61440);
    send_request(FUNC_TEST, 57999, 61440);
    send_request(FUNC_TEST, 58001, 61439);
    send_request(FUNC_TEST, 58000, 61441);
  endtask

  // last bit of the map, the top end and a walk over the full map
  task automatic test_map_extremes();
    send_request(FUNC_SET, MAP_SIZE - 1, MAP_SIZE);
    send_request(FUNC_TEST, MAP_SIZE - 1, MAP_SIZE);
    send_request(FUNC_SET, 61440, MAP_SIZE);
    send_request(FUNC_TEST, 61440, MAP_SIZE);
    send_request(FUNC_TEST, 0, 1);
    send_request(FUNC_TEST, 0, MAP_SIZE);
  endtask

  // windowed random traffic: each window gets sets, tests of what was just
  // set, tests of fresh ground, and some noise anywhere in the field ranges
  task automatic test_random_windows();
    int unsigned seq;
    int unsigned base;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    int unsigned set_lo;
    int unsigned set_hi;
    logic        f;
    seq = 0;
    while (random_sent < RANDOM_ITEMS) begin
      base   = (seq % WINDOW_COUNT) * WINDOW_BITS;
      set_lo = base;
      set_hi = base;
      repeat ($urandom_range(8, 24)) begin
        pick = $urandom_range(0, 99);
        f    = FUNC_TEST;
        if (pick < 30 || (pick < 50 && set_hi == set_lo)) begin
          // mark a span of the window and remember it
          f  = FUNC_SET;
          lo = base + $urandom_range(0, WINDOW_BITS - 1);
          hi = lo + pick_span();
          if (hi > base + WINDOW_BITS)
            hi = base + WINDOW_BITS;
          set_lo = lo;
          set_hi = hi;
        end else if (pick < 50) begin
          // probe inside the last marked span
          lo = $urandom_range(set_lo, set_hi - 1);
          hi = $urandom_range(lo + 1, set_hi);
        end else if (pick < 75) begin
          lo = base + $urandom_range(0, WINDOW_BITS - 1);
          hi = lo + pick_span();
          if (hi > base + WINDOW_BITS)
            hi = base + WINDOW_BITS;
        end else if (pick < 85) begin
          // empty or reversed
          f  = 1'($urandom_range(0, 1));
          lo = $urandom_range(0, 65535);
          hi = $urandom_range(0, lo);
        end else if (pick < 95) begin
          // right end past the map
          f  = 1'($urandom_range(0, 1));
          lo = $urandom_range(0, 65535);
          hi = $urandom_range(MAP_SIZE + 1, 131071);
        end else if (pick < 98) begin
          lo = $urandom_range(0, MAP_SIZE - 1);
          hi = lo + $urandom_range(1, 300);
          if (hi > MAP_SIZE)
            hi = MAP_SIZE;
        end else begin
          // rare walk from the low end of the map to a random end point
          lo = $urandom_range(0, 4095);
          hi = $urandom_range(lo + 1, MAP_SIZE);
        end
        send_request(f, lo, hi);
        random_sent++;
      end
      seq++;
    end
  endtask

  // reply checker: done is a one-cycle strobe, every one is a reply beat
  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with none owed: all_set %0d status %0d",
                 $time, all_set, status);
        err_cnt++;
      end else begin
        want = expected_replies.pop_front();
        if (all_set !== want.all_set) begin
          $display("%0t: all_set mismatch: expected %0d actual %0d",
                   $time, want.all_set, all_set);
          err_cnt++;
        end
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, status);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: count cycles with neither a request beat nor a reply
  always @(posedge clk) begin
    if ((!rst && start && !busy) || (!rst && done))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no beat for %0d cycles, %0d replies owed", $time,
             STALL_LIMIT, expected_replies.size());
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    for (int unsigned w = 0; w < MAP_WORDS; w++)
      map_words[w] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_rejected_ranges();
    test_word_edges();
    // hold off once so the unit runs completely dry mid-run
    wait_replies_drained();
    test_map_extremes();
    wait_replies_drained();
    test_random_windows();

    wait_replies_drained();
    // room for any stray late reply to show up
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d sets, %0d tests (%0d fully set), %0d rejected ranges",
             n_set, n_test, n_hits, n_rejected);
    $display("tb: %0d random requests over %0d windows, %0d errors",
             random_sent, WINDOW_COUNT, err_cnt);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hdl/brst_pkg.sv
hdl/brst_queue.sv
hdl/brst_front.sv
hdl/brst_back.sv
hdl/bitmap_range_set_and_test_unit.sv
bench/tb.sv
